// ----- src/cartesian_to_spherical_assert.svh -----
// assertion macros for the cartesian to spherical converter
// no dependencies; included by the top level only
`ifndef CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`ifndef SYNTHESIS
// condition in this cycle implies a consequence in the same cycle
`define CTS_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("cartesian_to_spherical: check failed");
// condition in this cycle implies a consequence in the next cycle
`define CTS_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("cartesian_to_spherical: check failed");
`else
`define CTS_ASSERT_NOW(label, clk, rst, cond, cons)
`define CTS_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif
`endif

// ----- src/cts_pkg.sv -----
// shared types, constants and tables of the cartesian to spherical converter
// no dependencies; used by every module of the block
package cts_pkg;

   // field widths
   localparam int COORD_WIDTH     = 16;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int POLAR_W         = 15;
   localparam int AZIM_W          = 16;
   localparam int RADIUS_W        = 16;

   // cordic datapath
   localparam int CORDIC_STEPS = 28;
   localparam int ACC_FRAC     = 24;
   localparam int ACC_W        = 32;
   localparam int CW           = 64;
   localparam int GUARD_SHIFT  = 60 - COORD_WIDTH;
   localparam int GAIN_SHIFT   = GUARD_SHIFT - 30;
   localparam int Q_W          = 35;
   localparam int ROUND_SHIFT  = ACC_FRAC - ANGLE_FRAC_BITS;

   // square root datapath
   localparam int SUM_W      = 2 * COORD_WIDTH;
   localparam int SQRT_STEPS = COORD_WIDTH;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   // pipeline stages of the back part
   localparam int NSTG = 2 * CORDIC_STEPS + 3;

   // cordic gain, Q30
   localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

   // angles in accumulator units
   localparam logic signed [ACC_W-1:0] ACC_DEG90 = ACC_W'(64'd90 << ACC_FRAC);
   localparam logic signed [Q_W-1:0] DEG90  = Q_W'(64'd90 << ACC_FRAC);
   localparam logic signed [Q_W-1:0] DEG180 = Q_W'(64'd180 << ACC_FRAC);
   localparam logic signed [Q_W-1:0] DEG270 = Q_W'(64'd270 << ACC_FRAC);
   localparam logic signed [Q_W-1:0] DEG360 = Q_W'(64'd360 << ACC_FRAC);
   localparam logic [Q_W-1:0] ROUND_HALF = Q_W'(64'd1 << (ROUND_SHIFT - 1));

   // angles in output units
   localparam logic [AZIM_W-1:0]  AZ_FULL   = AZIM_W'(32'd360 << ANGLE_FRAC_BITS);
   localparam logic [POLAR_W-1:0] POLAR_90  = POLAR_W'(32'd90 << ANGLE_FRAC_BITS);
   localparam logic [POLAR_W-1:0] POLAR_180 = POLAR_W'(32'd180 << ANGLE_FRAC_BITS);

   // arctangent table, units of 2^-24 degree
   localparam logic [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
      32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
      32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
      32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
      32'd115, 32'd57, 32'd29, 32'd14, 32'd7
   };

   // request item
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_coord;
      logic signed [COORD_WIDTH-1:0] y_coord;
      logic signed [COORD_WIDTH-1:0] z_coord;
   } req_type;

   // result item
   typedef struct packed {
      logic [POLAR_W-1:0]  polar_angle;
      logic [AZIM_W-1:0]   azimuth_angle;
      logic [RADIUS_W-1:0] radius;
      logic                on_axis_error;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic                   nx;
      logic                   ny;
      logic                   nz;
      logic                   ax_zero;
      logic                   ay_zero;
      logic                   az_zero;
      logic [COORD_WIDTH-1:0] ax;
      logic [COORD_WIDTH-1:0] ay;
      logic [COORD_WIDTH-1:0] az;
      logic [SUM_W-1:0]       sq_x;
      logic [SUM_W-1:0]       sq_y;
      logic [SUM_W-1:0]       sq_z;
   } item_type;

endpackage

// ----- src/cts_front.sv -----
// front part: takes request items, forms magnitudes, signs, squares and flags
// depends on cts_pkg
module cts_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  cts_pkg::req_type req_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cts_pkg::item_type out_item
);

   logic               valid_ff, valid_in;
   cts_pkg::item_type  item_ff, item_in;
   logic               accept;
   logic [cts_pkg::COORD_WIDTH-1:0] ux, uy, uz;

   // magnitudes and flags of the incoming vector
   always_comb begin
      ux = req_data.x_coord;
      uy = req_data.y_coord;
      uz = req_data.z_coord;
      item_in.nx = ux[cts_pkg::COORD_WIDTH-1];
      item_in.ny = uy[cts_pkg::COORD_WIDTH-1];
      item_in.nz = uz[cts_pkg::COORD_WIDTH-1];
      item_in.ax = item_in.nx ? (~ux + 1'b1) : ux;
      item_in.ay = item_in.ny ? (~uy + 1'b1) : uy;
      item_in.az = item_in.nz ? (~uz + 1'b1) : uz;
      item_in.ax_zero = (ux == '0);
      item_in.ay_zero = (uy == '0);
      item_in.az_zero = (uz == '0);
      item_in.sq_x = cts_pkg::SUM_W'(item_in.ax) * cts_pkg::SUM_W'(item_in.ax);
      item_in.sq_y = cts_pkg::SUM_W'(item_in.ay) * cts_pkg::SUM_W'(item_in.ay);
      item_in.sq_z = cts_pkg::SUM_W'(item_in.az) * cts_pkg::SUM_W'(item_in.az);
   end

   // one holding register ahead of the queue
   assign full     = valid_ff && !out_ready;
   assign accept   = push && !full;
   assign valid_in = accept || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- src/cts_queue.sv -----
// short queue that decouples the front part from the back part
// depends on cts_pkg
module cts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cts_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_pop,
   output cts_pkg::item_type out_item
);

   cts_pkg::item_type              store_ff [cts_pkg::QUEUE_DEPTH];
   logic [cts_pkg::QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [cts_pkg::QUEUE_CW-1:0]   count_ff, count_in;
   logic                           do_push, do_pop;

   assign in_ready  = (count_ff != cts_pkg::QUEUE_CW'(cts_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_pop && out_valid;
   assign out_item  = store_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- src/cts_back.sv -----
// back part: square root and two vectoring cordic passes, one stage per step
// depends on cts_pkg
module cts_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  cts_pkg::item_type q_item,
   output logic              out_valid,
   input  logic              out_pop,
   output cts_pkg::rsp_type  out_data
);

   typedef struct packed {
      logic                                nx;
      logic                                ny;
      logic                                nz;
      logic                                ax_zero;
      logic                                ay_zero;
      logic                                az_zero;
      logic [cts_pkg::COORD_WIDTH-1:0]     ay;
      logic signed [cts_pkg::CW-1:0]       cx;
      logic signed [cts_pkg::CW-1:0]       cy;
      logic signed [cts_pkg::ACC_W-1:0]    acc;
      logic [cts_pkg::ACC_W-1:0]           theta;
      logic [cts_pkg::SUM_W-1:0]           rem;
      logic [cts_pkg::SUM_W-1:0]           root;
      logic signed [cts_pkg::Q_W-1:0]      q_az;
      logic signed [cts_pkg::Q_W-1:0]      q_pol;
   } stage_type;

   localparam int NSTG = cts_pkg::NSTG;

   stage_type         stage_ff [NSTG];
   stage_type         stage_in [NSTG];
   logic [NSTG-1:0]   valid_ff;
   logic              out_valid_ff;
   cts_pkg::rsp_type  out_ff, out_in;
   logic              adv;

   // one vectoring micro-rotation
   function automatic stage_type cordic_step(stage_type s, int i);
      stage_type r;
      logic signed [cts_pkg::CW-1:0] dx, dy;
      r  = s;
      dx = s.cy >>> i;
      dy = s.cx >>> i;
      if (s.cy > 0) begin
         r.cx  = s.cx + dx;
         r.cy  = s.cy - dy;
         r.acc = s.acc + signed'(cts_pkg::ATAN_TAB[i]);
      end else begin
         r.cx  = s.cx - dx;
         r.cy  = s.cy + dy;
         r.acc = s.acc - signed'(cts_pkg::ATAN_TAB[i]);
      end
      return r;
   endfunction

   // one digit of the restoring square root
   function automatic stage_type sqrt_step(stage_type s, int i);
      stage_type r;
      logic [cts_pkg::SUM_W-1:0] bitv;
      logic [cts_pkg::SUM_W:0]   test;
      r    = s;
      bitv = cts_pkg::SUM_W'(1) << (cts_pkg::SUM_W - 2 - 2 * i);
      test = {1'b0, s.root} + {1'b0, bitv};
      if ({1'b0, s.rem} >= test) begin
         r.rem  = s.rem - test[cts_pkg::SUM_W-1:0];
         r.root = (s.root >> 1) + bitv;
      end else begin
         r.root = s.root >> 1;
      end
      return r;
   endfunction

   // limit an accumulated angle to 0..90 degrees
   function automatic logic [cts_pkg::ACC_W-1:0] clamp90(
      logic signed [cts_pkg::ACC_W-1:0] a);
      logic [cts_pkg::ACC_W-1:0] r;
      if (a < 0) begin
         r = '0;
      end else if (a > cts_pkg::ACC_DEG90) begin
         r = cts_pkg::ACC_DEG90;
      end else begin
         r = a;
      end
      return r;
   endfunction

   // whole pipeline moves unless the result register is held
   assign adv   = !out_valid_ff || out_pop;
   assign q_pop = adv && q_valid;

   // entry stage: sum of squares and first cordic operands
   always_comb begin
      stage_in[0]         = '0;
      stage_in[0].nx      = q_item.nx;
      stage_in[0].ny      = q_item.ny;
      stage_in[0].nz      = q_item.nz;
      stage_in[0].ax_zero = q_item.ax_zero;
      stage_in[0].ay_zero = q_item.ay_zero;
      stage_in[0].az_zero = q_item.az_zero;
      stage_in[0].ay      = q_item.ay;
      stage_in[0].cx      = signed'(cts_pkg::CW'(q_item.az) << cts_pkg::GUARD_SHIFT);
      stage_in[0].cy      = signed'(cts_pkg::CW'(q_item.ax) << cts_pkg::GUARD_SHIFT);
      stage_in[0].rem     = q_item.sq_x + q_item.sq_y + q_item.sq_z;
   end

   for (genvar k = 1; k < NSTG; k++) begin : g_stage
      if (k <= cts_pkg::CORDIC_STEPS) begin : g_pass1
         // azimuth rotations, square root digits alongside
         if (k - 1 < cts_pkg::SQRT_STEPS) begin : g_sq
            always_comb begin
               stage_in[k] = sqrt_step(cordic_step(stage_ff[k-1], k - 1), k - 1);
            end
         end else begin : g_nosq
            always_comb begin
               stage_in[k] = cordic_step(stage_ff[k-1], k - 1);
            end
         end
      end else if (k == cts_pkg::CORDIC_STEPS + 1) begin : g_mid
         // azimuth result, radius rounding, polar pass operands
         logic [cts_pkg::COORD_WIDTH+cts_pkg::GAIN_SHIFT-1:0]    ay_sh;
         logic [cts_pkg::COORD_WIDTH+cts_pkg::GAIN_SHIFT+30:0]   prod;
         always_comb begin
            ay_sh             = {stage_ff[k-1].ay, {cts_pkg::GAIN_SHIFT{1'b0}}};
            prod              = ay_sh * cts_pkg::GAIN_Q30;
            stage_in[k]       = stage_ff[k-1];
            stage_in[k].theta = clamp90(stage_ff[k-1].acc);
            stage_in[k].cx    = signed'(cts_pkg::CW'(prod));
            stage_in[k].cy    = stage_ff[k-1].cx;
            stage_in[k].acc   = '0;
            stage_in[k].root  = stage_ff[k-1].root +
               cts_pkg::SUM_W'(stage_ff[k-1].rem > stage_ff[k-1].root);
         end
      end else if (k < NSTG - 1) begin : g_pass2
         // polar rotations
         always_comb begin
            stage_in[k] = cordic_step(stage_ff[k-1], k - cts_pkg::CORDIC_STEPS - 2);
         end
      end else begin : g_fold
         // fold both angles into their quadrants
         logic signed [cts_pkg::Q_W-1:0] t, p;
         always_comb begin
            t           = signed'(cts_pkg::Q_W'(stage_ff[k-1].theta));
            p           = signed'(cts_pkg::Q_W'(clamp90(stage_ff[k-1].acc)));
            stage_in[k] = stage_ff[k-1];
            priority if (stage_ff[k-1].az_zero) begin
               stage_in[k].q_az = stage_ff[k-1].nx ? cts_pkg::DEG270 : cts_pkg::DEG90;
            end else if (stage_ff[k-1].ax_zero) begin
               stage_in[k].q_az = stage_ff[k-1].nz ? cts_pkg::DEG180 : '0;
            end else if (!stage_ff[k-1].nx) begin
               stage_in[k].q_az = stage_ff[k-1].nz ? (cts_pkg::DEG180 - t) : t;
            end else begin
               stage_in[k].q_az = stage_ff[k-1].nz ? (cts_pkg::DEG180 + t)
                                                   : (cts_pkg::DEG360 - t);
            end
            stage_in[k].q_pol = stage_ff[k-1].ny ? (cts_pkg::DEG180 - p) : p;
         end
      end
   end

   // rounding, wrap and special cases into the result register
   logic [cts_pkg::Q_W-1:0] az_sum, pol_sum;
   logic [cts_pkg::AZIM_W-1:0] az_round;
   always_comb begin
      az_sum   = stage_ff[NSTG-1].q_az + cts_pkg::ROUND_HALF;
      pol_sum  = stage_ff[NSTG-1].q_pol + cts_pkg::ROUND_HALF;
      az_round = cts_pkg::AZIM_W'(az_sum >> cts_pkg::ROUND_SHIFT);
      out_in.radius = cts_pkg::RADIUS_W'(stage_ff[NSTG-1].root);
      if (stage_ff[NSTG-1].ax_zero && stage_ff[NSTG-1].az_zero) begin
         out_in.on_axis_error = 1'b1;
         out_in.azimuth_angle = '0;
         out_in.polar_angle   = stage_ff[NSTG-1].ny ? cts_pkg::POLAR_180 : '0;
      end else begin
         out_in.on_axis_error = 1'b0;
         out_in.azimuth_angle = (az_round >= cts_pkg::AZ_FULL) ? '0 : az_round;
         out_in.polar_angle   = stage_ff[NSTG-1].ay_zero ? cts_pkg::POLAR_90 :
                                cts_pkg::POLAR_W'(pol_sum >> cts_pkg::ROUND_SHIFT);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[NSTG-2:0], q_valid};
         out_valid_ff <= valid_ff[NSTG-1];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NSTG; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// ----- src/cartesian_to_spherical.sv -----
// top level of the cartesian to spherical converter
// depends on cts_pkg, cts_front, cts_queue, cts_back and the assertion header
//
// Converts a signed vector (x, y, z), y being the polar axis, into radius,
// polar angle from +y and azimuth around y from +z toward +x, angles in
// 1/128 degree. x and z both zero sets on_axis_error.
// Input side is a queue port: an item enters when push is high and full is
// low. Result side is a queue port too: while empty is low the oldest result
// is on rsp_data and pop takes it.
// Throughput: one item per clock while results are popped. From push to
// empty falling an item passes one front register, one queue slot, 59 back
// stages (an entry stage, 28 cordic rotations for the azimuth, a gain
// multiply, 28 rotations for the polar angle, quadrant folding) and the
// result register. While a result waits and pop is low the back pipeline
// holds; the four-entry queue and the front register keep taking items
// until they fill, then full rises. Reset clears all valid state; the block
// is empty after it and needs no setup.
`include "cartesian_to_spherical_assert.svh"
module cartesian_to_spherical (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  cts_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output cts_pkg::rsp_type rsp_data
);

   logic              front_valid, q_ready, q_valid, q_pop, out_valid;
   cts_pkg::item_type front_item, q_item;

   // classify items
   cts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .out_valid (front_valid),
      .out_ready (q_ready),
      .out_item  (front_item)
   );

   // decoupling queue
   cts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (q_ready),
      .in_item   (front_item),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_item  (q_item)
   );

   // arithmetic pipeline
   cts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .out_valid (out_valid),
      .out_pop   (pop),
      .out_data  (rsp_data)
   );

   assign empty = !out_valid;

   // checks
   `CTS_ASSERT_NOW(a_onaxis_az, clock, reset, !empty && rsp_data.on_axis_error, rsp_data.azimuth_angle == '0)
   `CTS_ASSERT_NOW(a_az_range, clock, reset, !empty, rsp_data.azimuth_angle < cts_pkg::AZ_FULL)
   `CTS_ASSERT_NOW(a_pol_range, clock, reset, !empty, rsp_data.polar_angle <= cts_pkg::POLAR_180)
   `CTS_ASSERT_NOW(a_full_queue, clock, reset, full, !q_ready && front_valid)

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the cartesian to spherical converter
// depends on cts_pkg and the cartesian_to_spherical top level
// a scoreboard class predicts radius and angles of each vector and checks results in order
module tb_top;

   localparam int RANDOM_ITEMS = 550;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 80;

   // expected results of conversions in flight, oldest first
   class conversion_board;
      cts_pkg::rsp_type pending[$];
      int               errors;

      function new();
         pending = {};
         errors  = 0;
      endfunction

      // vectoring rotation toward y = 0, clamped angle in 2^-24 degree
      function automatic longint rotate_to_axis(inout longint vx, inout longint vy);
         longint ang;
         longint dx;
         longint dy;
         ang = 0;
         for (int i = 0; i < cts_pkg::CORDIC_STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
               vx += dx; vy -= dy; ang += longint'(cts_pkg::ATAN_TAB[i]);
            end else begin
               vx -= dx; vy += dy; ang -= longint'(cts_pkg::ATAN_TAB[i]);
            end
         end
         if (ang < 0) ang = 0;
         if (ang > (longint'(90) << cts_pkg::ACC_FRAC)) begin
            ang = longint'(90) << cts_pkg::ACC_FRAC;
         end
         return ang;
      endfunction

      function automatic longint unsigned round_deg(longint q);
         if (q < 0) q = 0;
         return (longint'(q) + (longint'(1) << (cts_pkg::ROUND_SHIFT - 1)))
                >> cts_pkg::ROUND_SHIFT;
      endfunction

      function automatic longint unsigned int_sqrt(longint unsigned s);
         longint unsigned res;
         longint unsigned b;
         res = 0;
         b   = 64'd1 << 62;
         while (b > s) b >>= 2;
         while (b != 0) begin
            if (s >= res + b) begin
               s  -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      // work out the result of one accepted vector
      function void note_vector(cts_pkg::req_type v);
         longint unsigned ax, ay, az, sum, r, hi, lo, polar, azim;
         longint cx, cy, px, py, t, p, q, d90, d180;
         bit nx, ny, nz, err;
         cts_pkg::rsp_type e;
         d90  = longint'(90) << cts_pkg::ACC_FRAC;
         d180 = longint'(180) << cts_pkg::ACC_FRAC;
         nx = v.x_coord[cts_pkg::COORD_WIDTH-1];
         ny = v.y_coord[cts_pkg::COORD_WIDTH-1];
         nz = v.z_coord[cts_pkg::COORD_WIDTH-1];
         ax = nx ? -longint'(v.x_coord) : longint'(v.x_coord);
         ay = ny ? -longint'(v.y_coord) : longint'(v.y_coord);
         az = nz ? -longint'(v.z_coord) : longint'(v.z_coord);
         sum = ax * ax + ay * ay + az * az;
         r = int_sqrt(sum);
         if (sum - r * r > r) r++;
         err = 0;
         if (ax == 0 && az == 0) begin
            err   = 1;
            azim  = 0;
            polar = ny ? (64'd180 << cts_pkg::ANGLE_FRAC_BITS) : 0;
         end else begin
            cx = longint'(az << cts_pkg::GUARD_SHIFT);
            cy = longint'(ax << cts_pkg::GUARD_SHIFT);
            t  = rotate_to_axis(cx, cy);
            if (az == 0)      q = nx ? 3 * d90 : d90;
            else if (ax == 0) q = nz ? d180 : 0;
            else if (!nx)     q = nz ? d180 - t : t;
            else              q = nz ? d180 + t : 4 * d90 - t;
            azim = round_deg(q);
            if (azim >= (64'd360 << cts_pkg::ANGLE_FRAC_BITS)) azim = 0;
            if (ay == 0) begin
               polar = 64'd90 << cts_pkg::ANGLE_FRAC_BITS;
            end else begin
               // |y| times the rotation gain, low part truncated
               hi = (ay << cts_pkg::GUARD_SHIFT) >> 30;
               lo = (ay << cts_pkg::GUARD_SHIFT) & ((64'd1 << 30) - 1);
               px = longint'(hi * cts_pkg::GAIN_Q30 + ((lo * cts_pkg::GAIN_Q30) >> 30));
               py = cx;
               p  = rotate_to_axis(px, py);
               polar = round_deg(ny ? d180 - p : p);
            end
         end
         e.polar_angle   = polar[cts_pkg::POLAR_W-1:0];
         e.azimuth_angle = azim[cts_pkg::AZIM_W-1:0];
         e.radius        = r[cts_pkg::RADIUS_W-1:0];
         e.on_axis_error = err;
         pending.push_back(e);
      endfunction

      // compare one popped result with the oldest expectation
      function void check_result(cts_pkg::rsp_type got);
         cts_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.polar_angle !== e.polar_angle) begin
            $display("%0t: polar_angle expected %0d actual %0d", $time,
                     e.polar_angle, got.polar_angle);
            errors++;
         end
         if (got.azimuth_angle !== e.azimuth_angle) begin
            $display("%0t: azimuth_angle expected %0d actual %0d", $time,
                     e.azimuth_angle, got.azimuth_angle);
            errors++;
         end
         if (got.radius !== e.radius) begin
            $display("%0t: radius expected %0d actual %0d", $time, e.radius, got.radius);
            errors++;
         end
         if (got.on_axis_error !== e.on_axis_error) begin
            $display("%0t: on_axis_error expected %0d actual %0d", $time,
                     e.on_axis_error, got.on_axis_error);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             push;
   logic             full;
   cts_pkg::req_type req_data;
   logic             empty;
   logic             pop;
   cts_pkg::rsp_type rsp_data;

   conversion_board  board;
   cts_pkg::req_type corner_list[$];
   int               sent;
   int               total_items;
   int               cycles;

   cartesian_to_spherical u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic logic signed [15:0] pick_coord(int kind);
      logic signed [15:0] c;
      case (kind)
         0: c = 16'($urandom_range(0, 65535));
         1: c = $signed(16'($urandom_range(0, 8))) - 16'sd4;
         2: c = 16'sd0;
         default: begin
            case ($urandom_range(0, 4))
               0: c = 16'sh7fff;
               1: c = 16'sh8000;
               2: c = 16'sd1;
               3: c = -16'sd1;
               default: c = 16'($urandom_range(0, 65535));
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic cts_pkg::req_type make_vector(int n);
      cts_pkg::req_type v;
      int style;
      if (n < corner_list.size()) return corner_list[n];
      style = $urandom_range(0, 9);
      v.x_coord = pick_coord(style == 1 ? 1 : (style == 3 ? 3 : 0));
      v.y_coord = pick_coord(style == 1 ? 1 : (style == 4 ? 2 : (style == 3 ? 3 : 0)));
      v.z_coord = pick_coord(style == 1 ? 1 : (style == 3 ? 3 : 0));
      // one horizontal component zero lands on an exact axis
      if (style == 2) begin
         if ($urandom_range(0, 1)) v.x_coord = 0;
         else v.z_coord = 0;
      end
      if (style == 5 && $urandom_range(0, 3) == 0) begin
         v.x_coord = 0; v.z_coord = 0;
      end
      return v;
   endfunction

   function automatic bit take_break(int n);
      // long quiet stretch with no idling
      if (n >= 200 && n < 320) return 0;
      return $urandom_range(0, 99) < 26;
   endfunction

   // directed corner vectors
   task automatic load_corners();
      corner_list.push_back('{16'sd0, 16'sd0, 16'sd0});
      corner_list.push_back('{16'sd0, 16'sd5, 16'sd0});
      corner_list.push_back('{16'sd0, -16'sd5, 16'sd0});
      corner_list.push_back('{16'sh7fff, 16'sd0, 16'sd0});
      corner_list.push_back('{16'sh8000, 16'sd0, 16'sd0});
      corner_list.push_back('{16'sd0, 16'sd0, 16'sh7fff});
      corner_list.push_back('{16'sd0, 16'sd0, 16'sh8000});
      corner_list.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
      corner_list.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
      corner_list.push_back('{16'sd1, 16'sd1, 16'sd1});
      corner_list.push_back('{-16'sd1, -16'sd1, -16'sd1});
      corner_list.push_back('{16'sd1, 16'sd0, -16'sd1});
      corner_list.push_back('{-16'sd1, 16'sd0, 16'sd1});
      corner_list.push_back('{16'sd5, 16'sd3, 16'sd0});
      corner_list.push_back('{-16'sd5, 16'sd3, 16'sd0});
      corner_list.push_back('{16'sd0, 16'sd3, 16'sd7});
      corner_list.push_back('{16'sd0, -16'sd3, -16'sd7});
      corner_list.push_back('{16'sd3, 16'sd0, 16'sd4});
      corner_list.push_back('{-16'sd1, 16'sd1, 16'sh7fff});
      corner_list.push_back('{16'sd0, 16'sh8000, 16'sd0});
      corner_list.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff});
   endtask

   // input side: hold an item until it is taken
   task automatic drive_vectors();
      sent = 0;
      while (sent < total_items) begin
         @(posedge clock);
         if (push && !full) sent++;
         if (push && !full) board.note_vector(req_data);
         if (!(push && full)) begin
            if (sent < total_items && !take_break(sent)) begin
               push     <= 1'b1;
               req_data <= make_vector(sent);
            end else begin
               push <= 1'b0;
            end
         end
      end
   endtask

   // result side: random stalls on pop
   task automatic collect_results();
      int pops;
      pops = 0;
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            board.check_result(rsp_data);
            pops++;
         end
         pop <= !take_break(pops);
      end
   endtask

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      board     = new();
      cycles    = 0;
      reset     = 1'b1;
      push      = 1'b0;
      pop       = 1'b0;
      req_data  = '0;
      load_corners();
      total_items = corner_list.size() + RANDOM_ITEMS;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         collect_results();
      join_none
      drive_vectors();
      @(posedge clock);
      push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+src
src/cts_pkg.sv
src/cts_front.sv
src/cts_queue.sv
src/cts_back.sv
src/cartesian_to_spherical.sv
bench/tb_top.sv
